[hdl/tac_pkg.sv]
// Shared constants and types for the thermistor ADC to Celsius converter.
// Used by tac_log2, tac_div and thermistor_adc_to_celsius; no dependencies.
package tac_pkg;

  localparam int ADC_FULL_SCALE_DEF = 1023;
  localparam int CODE_W = 10;
  localparam int CHAN_W = 4;
  localparam int RF_W = 20;
  localparam int TEMP_W = 17;
  localparam int NUM_W = CODE_W + RF_W;
  localparam int FRAC_W = 24;
  localparam int GUARD_COUNTS = 2;

  localparam logic [RF_W-1:0] RF_RESET = 20'd10000;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [38:0] SH_A_Q48 = 39'd420748795187;
  localparam logic [27:0] SH_B_Q40 = 28'd240815037;
  localparam logic [28:0] SH_C_Q48 = 29'd457087215;
  localparam logic [23:0] SH_D_Q48 = 24'd9695406;
  localparam logic [12:0] KELVIN_NUM = 13'd5463;
  localparam logic [4:0] KELVIN_DEN = 5'd20;

  localparam logic [17:0] TEMP_MAX_MAG = 18'd51200;
  localparam logic [17:0] TEMP_MIN_MAG = 18'd25600;

  // Pipeline depths of the two sub-units.
  localparam int LOG2_LAT = 2 + FRAC_W;
  localparam int DIV_QW = TEMP_W;
  localparam int DIV_LAT = DIV_QW + 2;
  localparam int DIV_NW = 70;
  localparam int DIV_DW = 53;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] chan;
    logic              ok;
  } side_t;

  typedef struct packed {
    logic ypos;
    logic neg;
  } sign_t;

endpackage

[hdl/tac_log2.sv]
// Pipelined base-2 logarithm, Q24 result, one sample per cycle while en is high.
// Leading-one detect, normalize, then one square-and-compare per stage.
// Depends on tac_pkg.
module tac_log2 #(
  parameter int XW = 30
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [XW-1:0]                       x,
  output logic [$clog2(XW)+tac_pkg::FRAC_W-1:0] y
);

  localparam int EW = $clog2(XW);
  localparam int FW = tac_pkg::FRAC_W;

  logic [EW-1:0] e_det;
  logic [EW-1:0] ea;
  logic [XW-1:0] xa;
  logic [EW-1:0] eb;
  logic [30:0]   mb;

  logic [30:0]   m_q [1:FW];
  logic [FW-1:0] f_q [1:FW];
  logic [EW-1:0] e_q [1:FW];

  always_comb begin
    e_det = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        e_det = EW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea <= e_det;
      xa <= x;
      eb <= ea;
      mb <= 31'(31'(xa) << (5'd30 - 5'(ea)));
    end
  end

  for (genvar k = 1; k <= FW; k++) begin : g_sq
    logic [30:0]   m_in;
    logic [FW-1:0] f_in;
    logic [EW-1:0] e_in;
    logic [61:0]   p;
    logic [31:0]   s;

    if (k == 1) begin : g_first
      assign m_in = mb;
      assign f_in = '0;
      assign e_in = eb;
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign f_in = f_q[k-1];
      assign e_in = e_q[k-1];
    end

    assign p = 62'(m_in) * 62'(m_in);
    assign s = p[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[k] <= s[31] ? s[31:1] : s[30:0];
        f_q[k] <= {f_in[FW-2:0], s[31]};
        e_q[k] <= e_in;
      end
    end
  end

  assign y = {e_q[FW], f_q[FW]};

endmodule

[hdl/tac_div.sv]
// Pipelined restoring divider: one quotient bit per stage, with an overflow
// check up front and a round-half-up decision at the end. Depends on tac_pkg.
module tac_div #(
  parameter int NW = tac_pkg::DIV_NW,
  parameter int DW = tac_pkg::DIV_DW,
  parameter int QW = tac_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] a,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf,
  output logic          rnd
);

  logic [NW-1:0] r0;
  logic [DW-1:0] d0;
  logic          ovf0;

  logic [NW-1:0] r_q   [1:QW];
  logic [DW-1:0] d_q   [1:QW];
  logic [QW-1:0] q_q   [1:QW];
  logic          ovf_q [1:QW];

  // A quotient of 2^QW or more cannot be represented and saturates later.
  always_ff @(posedge clk) begin
    if (en) begin
      r0   <= a;
      d0   <= d;
      ovf0 <= a >= (NW'(d) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ovf_in;
    logic [NW-1:0] trial;
    logic          take;

    if (k == 1) begin : g_first
      assign r_in   = r0;
      assign d_in   = d0;
      assign q_in   = '0;
      assign ovf_in = ovf0;
    end else begin : g_next
      assign r_in   = r_q[k-1];
      assign d_in   = d_q[k-1];
      assign q_in   = q_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    assign trial = NW'(d_in) << (QW - k);
    assign take  = r_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k]   <= take ? r_in - trial : r_in;
        d_q[k]   <= d_in;
        q_q[k]   <= {q_in[QW-2:0], take};
        ovf_q[k] <= ovf_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q   <= q_q[QW];
      ovf <= ovf_q[QW];
      rnd <= {r_q[QW], 1'b0} >= (NW+1)'(d_q[QW]);
    end
  end

endmodule

[hdl/thermistor_adc_to_celsius.sv]
// Thermistor divider ADC code to temperature in 1/256 degC, Steinhart-Hart.
// Top level; depends on tac_pkg, tac_log2 and tac_div.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  sample    | in        | sample_valid/sample_ready  | adc_code, channel
//  result    | out       | result_valid/result_ready  | celsius_q8, reading_valid,
//            |           |                            | adc_echo, channel_echo
//  cfg       | in        | cfg_valid/cfg_ready        | cfg_data (fixed resistor)
//
// One sample per cycle unless stalled; each result goes through the 24 log2 squaring stages
// and the 17 quotient-bit divider stages, among other registers.
// The whole pipeline advances together: it holds while a result waits unread.
// Synchronous reset clears the pipeline valid bits and result_valid and loads the resistor with 10000 ohms.
// cfg_ready is always high; writes take effect on the next accepted sample.
module thermistor_adc_to_celsius #(
  parameter int ADC_FULL_SCALE = tac_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [tac_pkg::CODE_W-1:0]        adc_code,
  input  logic [tac_pkg::CHAN_W-1:0]        channel,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [tac_pkg::TEMP_W-1:0] celsius_q8,
  output logic                              reading_valid,
  output logic [tac_pkg::CODE_W-1:0]        adc_echo,
  output logic [tac_pkg::CHAN_W-1:0]        channel_echo,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tac_pkg::RF_W-1:0]          cfg_data
);

  localparam int DEN_W = $clog2(ADC_FULL_SCALE + 1);
  localparam int NLG_W = $clog2(tac_pkg::NUM_W) + tac_pkg::FRAC_W;
  localparam int DLG_W = $clog2(DEN_W) + tac_pkg::FRAC_W;
  localparam int PRE = 1 + tac_pkg::LOG2_LAT + 12 + tac_pkg::DIV_LAT;
  localparam int NW = tac_pkg::DIV_NW;
  localparam int DW = tac_pkg::DIV_DW;

  logic en;
  logic [tac_pkg::RF_W-1:0] rf;

  tac_pkg::side_t side_in;
  tac_pkg::side_t side [0:PRE-1];
  logic           vld  [0:PRE-1];

  logic [tac_pkg::NUM_W-1:0] num1;
  logic [DEN_W-1:0]          den1;
  logic [NLG_W-1:0]          lg_num;
  logic [DLG_W-1:0]          lg_den;

  logic signed [30:0] diff;
  logic signed [61:0] prod;
  logic signed [61:0] prod_adj;
  logic signed [31:0] ln_r, ln_r1, ln_r2;
  logic signed [63:0] l2p, bp, bp_adj;
  logic signed [35:0] l2;
  logic signed [47:0] bterm, bterm3, bterm4, bterm5;
  logic signed [67:0] l3p, l3p_adj, cp;
  logic signed [43:0] l3;
  logic signed [47:0] cterm, cterm5;
  logic signed [67:0] dp, dp_adj;
  logic signed [47:0] y;
  logic signed [63:0] yk;
  logic [DW-1:0]      d37, d38, d39;
  logic               ypos37, ypos38, ypos39;
  logic signed [69:0] n38;
  logic [NW-1:0]      mag39;
  logic               neg39;

  tac_pkg::sign_t sgn [0:tac_pkg::DIV_LAT-1];

  logic [tac_pkg::DIV_QW-1:0] q;
  logic                       ovf;
  logic                       rnd;
  logic [17:0]                mag_r;

  logic signed [tac_pkg::TEMP_W-1:0] temp_next;
  logic                              valid_next;

  assign en           = !result_valid || result_ready;
  assign sample_ready = en;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rf <= tac_pkg::RF_RESET;
    end else if (cfg_valid) begin
      rf <= cfg_data;
    end
  end

  assign side_in.code = adc_code;
  assign side_in.chan = channel;
  assign side_in.ok   = (adc_code >= tac_pkg::CODE_W'(tac_pkg::GUARD_COUNTS))
                     && (17'(adc_code) + 17'(tac_pkg::GUARD_COUNTS) <= 17'(ADC_FULL_SCALE))
                     && (rf != '0);

  // Valid bits and sideband travel with the data and freeze together on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRE; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= sample_valid;
      for (int i = 1; i < PRE; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < PRE; i++) begin
        side[i] <= side[i-1];
      end
      num1 <= tac_pkg::NUM_W'(adc_code) * tac_pkg::NUM_W'(rf);
      den1 <= DEN_W'(ADC_FULL_SCALE) - DEN_W'(adc_code);
    end
  end

  tac_log2 #(.XW(tac_pkg::NUM_W)) u_log2_num (
    .clk (clk),
    .en  (en),
    .x   (num1),
    .y   (lg_num)
  );

  tac_log2 #(.XW(DEN_W)) u_log2_den (
    .clk (clk),
    .en  (en),
    .x   (den1),
    .y   (lg_den)
  );

  // Divisions by powers of two truncate toward zero, as in the fixed-point spec.
  assign prod_adj = prod + (prod[61] ? 62'sd1073741823 : 62'sd0);
  assign bp_adj   = bp + (bp[63] ? 64'sd65535 : 64'sd0);
  assign l3p_adj  = l3p + (l3p[67] ? 68'sd16777215 : 68'sd0);
  assign dp_adj   = dp + (dp[67] ? 68'sd16777215 : 68'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      diff   <= $signed(31'(lg_num)) - $signed(31'(lg_den));
      prod   <= diff * $signed({1'b0, tac_pkg::LN2_Q30});
      ln_r   <= 32'(prod_adj >>> 30);

      l2p    <= ln_r * ln_r;
      bp     <= ln_r * $signed({1'b0, tac_pkg::SH_B_Q40});
      ln_r1  <= ln_r;

      l2     <= 36'(l2p >>> 24);
      bterm  <= 48'(bp_adj >>> 16);
      ln_r2  <= ln_r1;

      l3p    <= l2 * ln_r2;
      cp     <= l2 * $signed({1'b0, tac_pkg::SH_C_Q48});
      bterm3 <= bterm;

      l3     <= 44'(l3p_adj >>> 24);
      cterm  <= 48'(cp >>> 24);
      bterm4 <= bterm3;

      dp     <= l3 * $signed({1'b0, tac_pkg::SH_D_Q48});
      cterm5 <= cterm;
      bterm5 <= bterm4;

      y      <= $signed(48'(tac_pkg::SH_A_Q48)) + bterm5 + cterm5 + 48'(dp_adj >>> 24);

      yk     <= y * $signed({1'b0, tac_pkg::KELVIN_NUM});
      d37    <= DW'(y) * DW'(tac_pkg::KELVIN_DEN);
      ypos37 <= !y[47] && (y != '0);

      n38    <= $signed(70'(tac_pkg::KELVIN_DEN) << 56) - (70'(yk) <<< 8);
      d38    <= d37;
      ypos38 <= ypos37;

      mag39  <= n38[69] ? NW'(-n38) : NW'(n38);
      neg39  <= n38[69];
      d39    <= d38;
      ypos39 <= ypos38;

      sgn[0] <= '{ypos: ypos39, neg: neg39};
      for (int i = 1; i < tac_pkg::DIV_LAT; i++) begin
        sgn[i] <= sgn[i-1];
      end
    end
  end

  tac_div #(.NW(NW), .DW(DW), .QW(tac_pkg::DIV_QW)) u_div (
    .clk (clk),
    .en  (en),
    .a   (mag39),
    .d   (d39),
    .q   (q),
    .ovf (ovf),
    .rnd (rnd)
  );

  assign mag_r = 18'(q) + 18'(rnd);

  always_comb begin
    temp_next  = '0;
    valid_next = 1'b0;
    if (side[PRE-1].ok && sgn[tac_pkg::DIV_LAT-1].ypos) begin
      if (sgn[tac_pkg::DIV_LAT-1].neg) begin
        if (ovf || mag_r > tac_pkg::TEMP_MIN_MAG) begin
          temp_next = -$signed(tac_pkg::TEMP_W'(tac_pkg::TEMP_MIN_MAG));
        end else begin
          temp_next  = -$signed(tac_pkg::TEMP_W'(mag_r));
          valid_next = 1'b1;
        end
      end else begin
        if (ovf || mag_r > tac_pkg::TEMP_MAX_MAG) begin
          temp_next = $signed(tac_pkg::TEMP_W'(tac_pkg::TEMP_MAX_MAG));
        end else begin
          temp_next  = $signed(tac_pkg::TEMP_W'(mag_r));
          valid_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld[PRE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      celsius_q8    <= temp_next;
      reading_valid <= valid_next;
      adc_echo      <= side[PRE-1].code;
      channel_echo  <= side[PRE-1].chan;
    end
  end

`ifndef SYNTH
  a_valid_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && reading_valid |-> (celsius_q8 >= -17'sd25600) && (celsius_q8 <= 17'sd51200))
    else $error("valid reading outside the temperature range");

  a_guard_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (adc_echo < tac_pkg::CODE_W'(tac_pkg::GUARD_COUNTS))
      |-> !reading_valid && (celsius_q8 == '0))
    else $error("guard band code gave a nonzero or valid reading");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> (vld[PRE-1] == $past(vld[PRE-1])) && (vld[0] == $past(vld[0])))
    else $error("pipeline moved during a stall");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for thermistor_adc_to_celsius: directed and random samples,
// randomized backpressure, resistor reconfiguration. Depends on tac_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct {
  logic signed [tac_pkg::TEMP_W-1:0] temp;
  logic                              ok;
  logic [tac_pkg::CODE_W-1:0]        code;
  logic [tac_pkg::CHAN_W-1:0]        chan;
} reading_t;

class ReadingScoreboard;
  logic [tac_pkg::RF_W-1:0] rf_ohms = tac_pkg::RF_RESET;
  reading_t pending[$];
  int errors = 0;
  int checked = 0;
  int valid_seen = 0;

  // Fixed-length log2 in Q24: exponent in the top bits, 24 squaring steps for the fraction.
  function longint log2_q24(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e <= 30) m = x << (30 - e);
    else m = x >> (e - 30);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return longint'((64'(e) << 24) | frac);
  endfunction

  function void note_sample(logic [tac_pkg::CODE_W-1:0] code, logic [tac_pkg::CHAN_W-1:0] chan);
    reading_t r;
    longint unsigned num, den;
    longint ln_r, l2, l3, y, n, d, t;
    r.code = code;
    r.chan = chan;
    r.temp = '0;
    r.ok = 1'b0;
    if (code >= tac_pkg::GUARD_COUNTS
        && code + tac_pkg::GUARD_COUNTS <= tac_pkg::ADC_FULL_SCALE_DEF && rf_ohms != 0) begin
      num = longint'(code) * longint'(rf_ohms);
      den = tac_pkg::ADC_FULL_SCALE_DEF - code;
      ln_r = ((log2_q24(num) - log2_q24(den)) * longint'(tac_pkg::LN2_Q30)) / (64'sd1 << 30);
      l2 = (ln_r * ln_r) / (64'sd1 << 24);
      l3 = (l2 * ln_r) / (64'sd1 << 24);
      y = longint'(tac_pkg::SH_A_Q48)
        + (longint'(tac_pkg::SH_B_Q40) * ln_r) / (64'sd1 << 16)
        + (longint'(tac_pkg::SH_C_Q48) * l2) / (64'sd1 << 24)
        + (longint'(tac_pkg::SH_D_Q48) * l3) / (64'sd1 << 24);
      if (y > 0) begin
        n = 20 * (64'sd1 << 56) - 5463 * 256 * y;
        d = 20 * y;
        // Round half away from zero.
        if (n >= 0) t = (n + d / 2) / d;
        else t = -((-n + d / 2) / d);
        if (t < -25600) t = -25600;
        else if (t > 51200) t = 51200;
        else r.ok = 1'b1;
        r.temp = t[tac_pkg::TEMP_W-1:0];
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(reading_t act);
    reading_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result temp=%0d ok=%0d code=%0d chan=%0d", $time,
               act.temp, act.ok, act.code, act.chan);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (exp_r.ok) valid_seen++;
    if (act.temp !== exp_r.temp || act.ok !== exp_r.ok || act.code !== exp_r.code
        || act.chan !== exp_r.chan) begin
      $display("%0t: mismatch expected temp=%0d ok=%0d code=%0d chan=%0d", $time,
               exp_r.temp, exp_r.ok, exp_r.code, exp_r.chan);
      $display("%0t:          actual   temp=%0d ok=%0d code=%0d chan=%0d", $time,
               act.temp, act.ok, act.code, act.chan);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int DRAIN_CYCLES = 70;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic [tac_pkg::CODE_W-1:0] adc_code = '0;
  logic [tac_pkg::CHAN_W-1:0] channel = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [tac_pkg::TEMP_W-1:0] celsius_q8;
  logic reading_valid;
  logic [tac_pkg::CODE_W-1:0] adc_echo;
  logic [tac_pkg::CHAN_W-1:0] channel_echo;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tac_pkg::RF_W-1:0] cfg_data = '0;

  ReadingScoreboard readings = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int idle_cycles = 0;
  int samples_sent = 0;

  thermistor_adc_to_celsius u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .adc_code(adc_code), .channel(channel),
    .result_valid(result_valid), .result_ready(result_ready),
    .celsius_q8(celsius_q8), .reading_valid(reading_valid),
    .adc_echo(adc_echo), .channel_echo(channel_echo),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random backpressure, plus a long hold-off when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    reading_t act;
    if (!rst && result_valid && result_ready) begin
      act.temp = celsius_q8;
      act.ok = reading_valid;
      act.code = adc_echo;
      act.chan = channel_echo;
      readings.check_result(act);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("thermistor_adc_to_celsius verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample beat; valid stays up from the previous beat when no gap is taken.
  task automatic send_sample(input logic [tac_pkg::CODE_W-1:0] code,
                             input logic [tac_pkg::CHAN_W-1:0] chan);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    adc_code <= code;
    channel <= chan;
    do @(posedge clk); while (!sample_ready);
    readings.note_sample(code, chan);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    sample_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (readings.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_resistor(input logic [tac_pkg::RF_W-1:0] ohms);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= ohms;
    do @(posedge clk); while (!cfg_ready);
    readings.rf_ohms = ohms;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_samples(input int count);
    logic [tac_pkg::CODE_W-1:0] code;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) code = 10'($urandom_range(1023));
      else code = 10'($urandom_range(1021, 2));
      send_sample(code, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    logic [tac_pkg::CODE_W-1:0] edge_codes[13];
    logic [tac_pkg::RF_W-1:0] rf_set[7];
    edge_codes = '{0, 1, 2, 3, 10, 100, 341, 511, 512, 900, 1020, 1021, 1022};
    rf_set = '{20'd10000, 20'd1, 20'd1000000, 20'hFFFFF, 20'd100, 20'd0, 20'd47000};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: guard band edges, mid codes, all channel bits, then zero, one-ohm and full-scale resistors.
    write_resistor(tac_pkg::RF_RESET);
    recv_idle_pct = 20;
    foreach (edge_codes[i]) send_sample(edge_codes[i], i[3:0]);
    send_sample(10'd1023, 4'hF);
    send_sample(10'd682, 4'hA);
    send_sample(10'd341, 4'h5);
    write_resistor(20'd0);
    send_sample(10'd511, 4'h3);
    send_sample(10'd2, 4'hC);
    write_resistor(20'd1);
    send_sample(10'd2, 4'h1);
    send_sample(10'd1021, 4'h2);
    write_resistor(20'hFFFFF);
    send_sample(10'd2, 4'h4);
    send_sample(10'd1021, 4'h8);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 28 : 0;
      foreach (rf_set[k]) begin
        write_resistor((k == 6) ? 20'($urandom_range(1000000, 1)) : rf_set[k]);
        random_samples(64);
      end
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        hold_request = 300;
        random_samples(150);
        stop_sending();
        while (readings.pending.size() != 0) @(posedge clk);
        @(negedge clk);
        random_samples(40);
      end
    end

    wait_drained();
    $display("Checked %0d results from %0d samples (%0d in range) over several resistor values",
             readings.checked, samples_sent, readings.valid_seen);
    $display("with guard band, zero resistor, saturation and backpressure cases.");
    if (readings.errors == 0 && readings.pending.size() == 0) begin
      $display("thermistor_adc_to_celsius verification clean");
    end else begin
      $display("thermistor_adc_to_celsius verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/tac_pkg.sv
hdl/tac_log2.sv
hdl/tac_div.sv
hdl/thermistor_adc_to_celsius.sv
tb/sv/testbench.sv
